// File: hw/rtl/g2e_pkg.sv
package g2e_pkg;

  localparam int ANGLE_FRAC_BITS = 29;
  localparam int CORDIC_STAGES   = 32;
  localparam int SQRT_STAGES     = 32;
  localparam int DIV_STAGES      = 50;
  localparam int R16_SHIFT       = 46;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C234;
  localparam logic [63:0] LIM_LAT_W   = PI_Q62 >> (63 - ANGLE_FRAC_BITS);
  localparam logic [63:0] LIM_LON_W   = PI_Q62 >> (62 - ANGLE_FRAC_BITS);
  localparam logic [63:0] PI_Q30_W    = (PI_Q62 + 64'h8000_0000) >> 32;
  localparam logic [63:0] HPI_Q30_W   = (PI_Q62 + 64'h1_0000_0000) >> 33;
  localparam logic signed [35:0] PI_Q30      = $signed(PI_Q30_W[35:0]);
  localparam logic signed [35:0] HALF_PI_Q30 = $signed(HPI_Q30_W[35:0]);
  localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  localparam logic signed [35:0] OUT_MAX = 36'sh7_FFFF_FFFF;
  localparam logic signed [35:0] OUT_MIN = 36'sh8_0000_0000;

  localparam logic [32:0] RADIUS_RST = 33'd6378137000;
  localparam logic [31:0] RATIO_RST  = 32'd4266215153;
  localparam logic [31:0] ECC_RST    = 32'd28945915;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_RATIO  = 2'd1;
  localparam logic [1:0] CFG_ECC    = 2'd2;

  typedef struct packed {
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [31:0] altitude_mm;
  } in_item_t;

  typedef struct packed {
    logic signed [35:0] ecef_x;
    logic signed [35:0] ecef_y;
    logic signed [35:0] ecef_z;
    logic               coord_invalid;
  } out_item_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic               invalid;
    logic               flip;
    logic signed [31:0] h;
    logic signed [35:0] latq;
    logic signed [35:0] lonq;
  } q_item_t;

  // Side values that travel with a request through the back end.
  typedef struct packed {
    logic               valid;
    logic               invalid;
    logic               flip;
    logic signed [31:0] h;
    logic signed [35:0] clat;
    logic signed [35:0] slat;
    logic signed [35:0] clon;
    logic signed [35:0] slon;
    logic signed [35:0] cg;
    logic signed [35:0] sg;
    logic signed [55:0] z16;
  } ctx_t;

  function automatic logic signed [35:0] cordic_atan(input int idx);
    logic signed [35:0] res;
    case (idx)
      0: res = 36'sd843314857;
      1: res = 36'sd497837829;
      2: res = 36'sd263043837;
      3: res = 36'sd133525159;
      4: res = 36'sd67021687;
      5: res = 36'sd33543516;
      6: res = 36'sd16775851;
      7: res = 36'sd8388437;
      8: res = 36'sd4194283;
      9: res = 36'sd2097149;
      default: begin
        if (idx <= 30) res = 36'sd1 <<< (30 - idx);
        else if (idx == 31) res = 36'sd1;
        else res = 36'sd0;
      end
    endcase
    return res;
  endfunction

endpackage

// File: hw/rtl/g2e_front.sv
module g2e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  input  g2e_pkg::in_item_t  req_item,
  output logic               item_valid,
  output g2e_pkg::q_item_t   item
);

  logic [32:0]        alat;
  logic [32:0]        alon;
  logic signed [35:0] latq;
  logic signed [35:0] lonq;
  logic signed [35:0] lonf;
  logic               flip;
  logic               item_valid_r;
  g2e_pkg::q_item_t   item_r;
  g2e_pkg::q_item_t   item_nxt;

  always_comb begin
    alat = req_item.latitude[31] ? 33'(-{req_item.latitude[31], req_item.latitude})
                                 : {1'b0, req_item.latitude};
    alon = req_item.longitude[31] ? 33'(-{req_item.longitude[31], req_item.longitude})
                                  : {1'b0, req_item.longitude};
    latq = 36'(req_item.latitude)  <<< (30 - g2e_pkg::ANGLE_FRAC_BITS);
    lonq = 36'(req_item.longitude) <<< (30 - g2e_pkg::ANGLE_FRAC_BITS);
    // Longitudes past a right angle are folded by pi; the back end negates cos and sin.
    if (lonq > g2e_pkg::HALF_PI_Q30) begin
      lonf = lonq - g2e_pkg::PI_Q30;
      flip = 1'b1;
    end else if (lonq < -g2e_pkg::HALF_PI_Q30) begin
      lonf = lonq + g2e_pkg::PI_Q30;
      flip = 1'b1;
    end else begin
      lonf = lonq;
      flip = 1'b0;
    end
    item_nxt.invalid = (alat > g2e_pkg::LIM_LAT_W[32:0]) || (alon > g2e_pkg::LIM_LON_W[32:0]);
    item_nxt.flip    = flip;
    item_nxt.h       = req_item.altitude_mm;
    item_nxt.latq    = latq;
    item_nxt.lonq    = lonf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= req_valid;
    end
    item_r <= item_nxt;
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule

// File: hw/rtl/g2e_queue.sv
module g2e_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  g2e_pkg::q_item_t  push_item,
  output logic              pop_valid,
  output g2e_pkg::q_item_t  pop_item,
  output logic              almost_full
);

  g2e_pkg::q_item_t                 mem_r [g2e_pkg::QUEUE_DEPTH];
  logic [g2e_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [g2e_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [g2e_pkg::QCNT_W-1:0]       count_r;
  logic [g2e_pkg::QCNT_W-1:0]       count_nxt;
  logic                             pop;

  // The back end never stalls, so an entry leaves as soon as it is present.
  assign pop       = (count_r != '0);
  assign pop_valid = pop;
  assign pop_item  = mem_r[rd_ptr_r];
  assign almost_full = (count_r >= g2e_pkg::QCNT_W'(g2e_pkg::QUEUE_DEPTH - 2));

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// File: hw/rtl/g2e_cordic.sv
module g2e_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vec_mode,
  input  logic signed [35:0] x_i,
  input  logic signed [35:0] y_i,
  input  logic signed [35:0] z_i,
  input  g2e_pkg::ctx_t      ctx_i,
  output logic signed [35:0] x_o,
  output logic signed [35:0] y_o,
  output logic signed [35:0] z_o,
  output g2e_pkg::ctx_t      ctx_o
);

  localparam int N = g2e_pkg::CORDIC_STAGES;

  logic signed [35:0] x_r [N];
  logic signed [35:0] y_r [N];
  logic signed [35:0] z_r [N];
  g2e_pkg::ctx_t      ctx_r [N];
  logic signed [35:0] xp [N];
  logic signed [35:0] yp [N];
  logic signed [35:0] zp [N];
  g2e_pkg::ctx_t      cp [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [35:0] ATAN_I = g2e_pkg::cordic_atan(i);
    logic               dir;
    logic signed [35:0] dx;
    logic signed [35:0] dy;

    if (i == 0) begin : g_first
      assign xp[i] = x_i;
      assign yp[i] = y_i;
      assign zp[i] = z_i;
      assign cp[i] = ctx_i;
    end else begin : g_next
      assign xp[i] = x_r[i-1];
      assign yp[i] = y_r[i-1];
      assign zp[i] = z_r[i-1];
      assign cp[i] = ctx_r[i-1];
    end

    // Rotation steers on the residual angle, vectoring on the sign of y.
    assign dir = vec_mode ? yp[i][35] : !zp[i][35];
    assign dx  = yp[i] >>> i;
    assign dy  = xp[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctx_r[i] <= '0;
      end else begin
        ctx_r[i] <= cp[i];
      end
      if (dir) begin
        x_r[i] <= xp[i] - dx;
        y_r[i] <= yp[i] + dy;
        z_r[i] <= zp[i] - ATAN_I;
      end else begin
        x_r[i] <= xp[i] + dx;
        y_r[i] <= yp[i] - dy;
        z_r[i] <= zp[i] + ATAN_I;
      end
    end
  end

  assign x_o   = x_r[N-1];
  assign y_o   = y_r[N-1];
  assign z_o   = z_r[N-1];
  assign ctx_o = ctx_r[N-1];

endmodule

// File: hw/rtl/g2e_mulq.sv
module g2e_mulq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [51:0] a_i,
  input  logic signed [32:0] c_i,
  input  logic               sh32,
  input  g2e_pkg::ctx_t      ctx_i,
  output logic signed [55:0] p_o,
  output g2e_pkg::ctx_t      ctx_o
);

  logic               neg1_r;
  logic [51:0]        ma1_r;
  logic [32:0]        mc1_r;
  logic               sh1_r;
  g2e_pkg::ctx_t      ctx1_r;
  logic               neg2_r;
  logic [58:0]        pl2_r;
  logic [58:0]        ph2_r;
  logic               sh2_r;
  g2e_pkg::ctx_t      ctx2_r;
  logic signed [55:0] p3_r;
  g2e_pkg::ctx_t      ctx3_r;
  logic [84:0]        sum;
  logic [84:0]        res;

  // Magnitude product rounded half up, then the sign restored: ties go away from zero.
  always_comb begin
    sum = {ph2_r, 26'b0} + 85'(pl2_r) + (sh2_r ? (85'd1 << 31) : (85'd1 << 29));
    res = sh2_r ? (sum >> 32) : (sum >> 30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx1_r <= '0;
      ctx2_r <= '0;
      ctx3_r <= '0;
    end else begin
      ctx1_r <= ctx_i;
      ctx2_r <= ctx1_r;
      ctx3_r <= ctx2_r;
    end
    neg1_r <= a_i[51] ^ c_i[32];
    ma1_r  <= a_i[51] ? 52'(-a_i) : 52'(a_i);
    mc1_r  <= c_i[32] ? 33'(-c_i) : 33'(c_i);
    sh1_r  <= sh32;
    neg2_r <= neg1_r;
    pl2_r  <= 59'(ma1_r[25:0]) * 59'(mc1_r);
    ph2_r  <= 59'(ma1_r[51:26]) * 59'(mc1_r);
    sh2_r  <= sh1_r;
    p3_r   <= neg2_r ? -$signed(res[55:0]) : $signed(res[55:0]);
  end

  assign p_o   = p3_r;
  assign ctx_o = ctx3_r;

endmodule

// File: hw/rtl/g2e_sqrt.sv
module g2e_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [31:0]   d_i,
  input  g2e_pkg::ctx_t ctx_i,
  output logic [31:0]   s_o,
  output g2e_pkg::ctx_t ctx_o
);

  localparam int N = g2e_pkg::SQRT_STAGES;

  logic [35:0]   rem_r  [N];
  logic [31:0]   root_r [N];
  logic [63:0]   v_r    [N];
  g2e_pkg::ctx_t ctx_r  [N];
  logic [35:0]   remp   [N];
  logic [31:0]   rootp  [N];
  logic [63:0]   vp     [N];
  g2e_pkg::ctx_t cp     [N];

  // One root bit per stage from the radicand D * 2^30.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [35:0] rem_sh;
    logic [35:0] trial;

    if (i == 0) begin : g_first
      assign remp[i]  = '0;
      assign rootp[i] = '0;
      assign vp[i]    = {2'b0, d_i, 30'b0};
      assign cp[i]    = ctx_i;
    end else begin : g_next
      assign remp[i]  = rem_r[i-1];
      assign rootp[i] = root_r[i-1];
      assign vp[i]    = v_r[i-1];
      assign cp[i]    = ctx_r[i-1];
    end

    assign rem_sh = {remp[i][33:0], vp[i][63:62]};
    assign trial  = {2'b0, rootp[i], 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctx_r[i] <= '0;
      end else begin
        ctx_r[i] <= cp[i];
      end
      v_r[i] <= {vp[i][61:0], 2'b0};
      if (rem_sh >= trial) begin
        rem_r[i]  <= rem_sh - trial;
        root_r[i] <= {rootp[i][30:0], 1'b1};
      end else begin
        rem_r[i]  <= rem_sh;
        root_r[i] <= {rootp[i][30:0], 1'b0};
      end
    end
  end

  assign s_o   = root_r[N-1];
  assign ctx_o = ctx_r[N-1];

endmodule

// File: hw/rtl/g2e_div.sv
module g2e_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [32:0]   a_i,
  input  logic [31:0]   s_i,
  input  g2e_pkg::ctx_t ctx_i,
  output logic [49:0]   q_o,
  output g2e_pkg::ctx_t ctx_o
);

  localparam int N  = g2e_pkg::DIV_STAGES;
  localparam int SH = g2e_pkg::R16_SHIFT;

  logic [33:0]   rem_r [N];
  logic [49:0]   q_r   [N];
  logic [31:0]   s_r   [N];
  g2e_pkg::ctx_t ctx_r [N];
  logic [33:0]   remp  [N];
  logic [49:0]   qp    [N];
  logic [31:0]   sp    [N];
  g2e_pkg::ctx_t cp    [N];

  // Restoring division of a * 2^46 by S, one quotient bit per stage. The bits of
  // the dividend above the quotient range stay below S, so they seed the remainder.
  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int BI = N - 1 - j;
    logic        nbit;
    logic [33:0] rem_sh;

    if (j == 0) begin : g_first
      assign remp[j] = 34'(a_i >> (N - SH));
      assign qp[j]   = '0;
      assign sp[j]   = s_i;
      assign cp[j]   = ctx_i;
    end else begin : g_next
      assign remp[j] = rem_r[j-1];
      assign qp[j]   = q_r[j-1];
      assign sp[j]   = s_r[j-1];
      assign cp[j]   = ctx_r[j-1];
    end

    if (BI >= SH) begin : g_abit
      assign nbit = a_i[BI - SH];
    end else begin : g_zbit
      assign nbit = 1'b0;
    end

    assign rem_sh = {remp[j][32:0], nbit};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctx_r[j] <= '0;
      end else begin
        ctx_r[j] <= cp[j];
      end
      s_r[j] <= sp[j];
      if (rem_sh >= {2'b0, sp[j]}) begin
        rem_r[j] <= rem_sh - {2'b0, sp[j]};
        q_r[j]   <= {qp[j][48:0], 1'b1};
      end else begin
        rem_r[j] <= rem_sh;
        q_r[j]   <= {qp[j][48:0], 1'b0};
      end
    end
  end

  assign q_o   = q_r[N-1];
  assign ctx_o = ctx_r[N-1];

endmodule

// File: hw/rtl/g2e_back.sv
module g2e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  g2e_pkg::q_item_t    in_item,
  input  logic [32:0]         radius,
  input  logic [31:0]         ratio,
  input  logic [31:0]         ecc,
  output logic                res_valid,
  output g2e_pkg::out_item_t  res_item
);

  g2e_pkg::ctx_t      ctx_a_in, ctx_a, ctx_b_in, ctx_b, ctx_c, ctx_d_raw, ctx_d_in;
  g2e_pkg::ctx_t      ctx_e, ctx_f, ctx_g, ctx_h, ctx_i_r, ctx_i_nxt, ctx_rc, ctx_j;
  logic signed [35:0] clat_w, slat_w, clon_w, slon_w, g_w, cg_w, sg_w;
  logic signed [55:0] ky_p, s2_p, es2_p, p_rc, p_hc, p_rs, p_hs, px_p, py_p;
  logic signed [55:0] rho_r;
  logic [31:0]        d_w;
  logic [31:0]        s_w;
  logic [49:0]        r16_w;
  logic signed [51:0] r16_a;
  logic signed [51:0] h16_a;
  logic               res_valid_r;
  g2e_pkg::out_item_t res_item_r;
  g2e_pkg::out_item_t res_item_nxt;

  function automatic logic signed [35:0] to_mm(input logic signed [55:0] q16);
    logic signed [56:0] t;
    logic signed [40:0] v;
    t = 57'(q16) + 57'sd32768;
    v = 41'(t >>> 16);
    if (v > 41'(g2e_pkg::OUT_MAX)) return g2e_pkg::OUT_MAX;
    if (v < 41'(g2e_pkg::OUT_MIN)) return g2e_pkg::OUT_MIN;
    return v[35:0];
  endfunction

  always_comb begin
    ctx_a_in         = '0;
    ctx_a_in.valid   = in_valid;
    ctx_a_in.invalid = in_item.invalid;
    ctx_a_in.flip    = in_item.flip;
    ctx_a_in.h       = in_item.h;
  end

  g2e_cordic u_lat (
    .clk, .rst_n, .vec_mode(1'b0),
    .x_i(g2e_pkg::CORDIC_GAIN), .y_i('0), .z_i(in_item.latq), .ctx_i(ctx_a_in),
    .x_o(clat_w), .y_o(slat_w), .z_o(), .ctx_o(ctx_a)
  );

  g2e_cordic u_lon (
    .clk, .rst_n, .vec_mode(1'b0),
    .x_i(g2e_pkg::CORDIC_GAIN), .y_i('0), .z_i(in_item.lonq), .ctx_i(ctx_a_in),
    .x_o(clon_w), .y_o(slon_w), .z_o(), .ctx_o()
  );

  always_comb begin
    ctx_b_in      = ctx_a;
    ctx_b_in.clat = clat_w;
    ctx_b_in.slat = slat_w;
    ctx_b_in.clon = ctx_a.flip ? -clon_w : clon_w;
    ctx_b_in.slon = ctx_a.flip ? -slon_w : slon_w;
  end

  g2e_mulq u_ky (
    .clk, .rst_n, .a_i(52'(ctx_b_in.slat)), .c_i({1'b0, ratio}), .sh32(1'b1),
    .ctx_i(ctx_b_in), .p_o(ky_p), .ctx_o(ctx_b)
  );

  // Geocentric latitude as the angle of (cos lat, k sin lat).
  g2e_cordic u_vec (
    .clk, .rst_n, .vec_mode(1'b1),
    .x_i(ctx_b.clat), .y_i(ky_p[35:0]), .z_i('0), .ctx_i(ctx_b),
    .x_o(), .y_o(), .z_o(g_w), .ctx_o(ctx_c)
  );

  g2e_cordic u_geo (
    .clk, .rst_n, .vec_mode(1'b0),
    .x_i(g2e_pkg::CORDIC_GAIN), .y_i('0), .z_i(g_w), .ctx_i(ctx_c),
    .x_o(cg_w), .y_o(sg_w), .z_o(), .ctx_o(ctx_d_raw)
  );

  always_comb begin
    ctx_d_in    = ctx_d_raw;
    ctx_d_in.cg = cg_w;
    ctx_d_in.sg = sg_w;
  end

  g2e_mulq u_s2 (
    .clk, .rst_n, .a_i(52'(ctx_d_in.sg)), .c_i(ctx_d_in.sg[32:0]), .sh32(1'b0),
    .ctx_i(ctx_d_in), .p_o(s2_p), .ctx_o(ctx_e)
  );

  g2e_mulq u_es2 (
    .clk, .rst_n, .a_i(s2_p[51:0]), .c_i({1'b0, ecc}), .sh32(1'b1),
    .ctx_i(ctx_e), .p_o(es2_p), .ctx_o(ctx_f)
  );

  assign d_w = g2e_pkg::ONE_Q30 + es2_p[31:0];

  g2e_sqrt u_sqrt (.clk, .rst_n, .d_i(d_w), .ctx_i(ctx_f), .s_o(s_w), .ctx_o(ctx_g));

  g2e_div u_div (.clk, .rst_n, .a_i(radius), .s_i(s_w), .ctx_i(ctx_g),
    .q_o(r16_w), .ctx_o(ctx_h));

  assign r16_a = $signed({2'b0, r16_w});
  assign h16_a = $signed({{4{ctx_h.h[31]}}, ctx_h.h, 16'b0});

  g2e_mulq u_rc (
    .clk, .rst_n, .a_i(r16_a), .c_i(ctx_h.cg[32:0]), .sh32(1'b0),
    .ctx_i(ctx_h), .p_o(p_rc), .ctx_o(ctx_rc)
  );
  g2e_mulq u_hc (
    .clk, .rst_n, .a_i(h16_a), .c_i(ctx_h.clat[32:0]), .sh32(1'b0),
    .ctx_i(ctx_h), .p_o(p_hc), .ctx_o()
  );
  g2e_mulq u_rs (
    .clk, .rst_n, .a_i(r16_a), .c_i(ctx_h.sg[32:0]), .sh32(1'b0),
    .ctx_i(ctx_h), .p_o(p_rs), .ctx_o()
  );
  g2e_mulq u_hs (
    .clk, .rst_n, .a_i(h16_a), .c_i(ctx_h.slat[32:0]), .sh32(1'b0),
    .ctx_i(ctx_h), .p_o(p_hs), .ctx_o()
  );

  always_comb begin
    ctx_i_nxt     = ctx_rc;
    ctx_i_nxt.z16 = p_rs + p_hs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_i_r <= '0;
    end else begin
      ctx_i_r <= ctx_i_nxt;
    end
    rho_r <= p_rc + p_hc;
  end

  g2e_mulq u_x (
    .clk, .rst_n, .a_i(rho_r[51:0]), .c_i(ctx_i_r.clon[32:0]), .sh32(1'b0),
    .ctx_i(ctx_i_r), .p_o(px_p), .ctx_o(ctx_j)
  );
  g2e_mulq u_y (
    .clk, .rst_n, .a_i(rho_r[51:0]), .c_i(ctx_i_r.slon[32:0]), .sh32(1'b0),
    .ctx_i(ctx_i_r), .p_o(py_p), .ctx_o()
  );

  always_comb begin
    res_item_nxt.coord_invalid = ctx_j.invalid;
    if (ctx_j.invalid) begin
      res_item_nxt.ecef_x = '0;
      res_item_nxt.ecef_y = '0;
      res_item_nxt.ecef_z = '0;
    end else begin
      res_item_nxt.ecef_x = to_mm(px_p);
      res_item_nxt.ecef_y = to_mm(py_p);
      res_item_nxt.ecef_z = to_mm(ctx_j.z16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= ctx_j.valid;
    end
    res_item_r <= res_item_nxt;
  end

  assign res_valid = res_valid_r;
  assign res_item  = res_item_r;

endmodule

// File: hw/rtl/geodetic_to_ecef.sv
// Geodetic to ECEF converter. A request (latitude and longitude in radians with
// 29 fraction bits, altitude in mm) is taken at a clock edge where start is high
// and busy is low; one point can be taken every cycle while busy stays low. Each request produces
// exactly one result, in request order, shown for a single cycle with out_strobe
// high. Between the edge that took a request and its strobe lie the input register,
// the queue register, the three chained CORDIC pipelines, the 32-stage square root,
// the 50-stage divider that forms the prime-vertical radius and the multiplier stages.
// The result cannot be held off, so the receiver must take it in that cycle. Busy
// rises only if the short queue between the input stage and the datapath is half full,
// which does not happen in normal use. Registers are written through
// cfg_we/cfg_index/cfg_wdata and must only change while no request is in flight.
module geodetic_to_ecef (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  g2e_pkg::in_item_t   in_data,
  output logic                out_strobe,
  output g2e_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [32:0]         cfg_wdata
);

  logic [32:0]      radius_r;
  logic [31:0]      ratio_r;
  logic [31:0]      ecc_r;
  logic             accept;
  logic             fr_valid;
  g2e_pkg::q_item_t fr_item;
  logic             q_valid;
  g2e_pkg::q_item_t q_item;
  logic             q_almost_full;

  assign busy   = q_almost_full;
  assign accept = start && !q_almost_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= g2e_pkg::RADIUS_RST;
      ratio_r  <= g2e_pkg::RATIO_RST;
      ecc_r    <= g2e_pkg::ECC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        g2e_pkg::CFG_RADIUS: radius_r <= cfg_wdata;
        g2e_pkg::CFG_RATIO:  ratio_r  <= cfg_wdata[31:0];
        g2e_pkg::CFG_ECC:    ecc_r    <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  g2e_front u_front (
    .clk, .rst_n, .req_valid(accept), .req_item(in_data),
    .item_valid(fr_valid), .item(fr_item)
  );

  g2e_queue u_queue (
    .clk, .rst_n, .push(fr_valid), .push_item(fr_item),
    .pop_valid(q_valid), .pop_item(q_item), .almost_full(q_almost_full)
  );

  g2e_back u_back (
    .clk, .rst_n, .in_valid(q_valid), .in_item(q_item),
    .radius(radius_r), .ratio(ratio_r), .ecc(ecc_r),
    .res_valid(out_strobe), .res_item(out_data)
  );

endmodule

// File: hw/rtl/g2e_checker.sv
module g2e_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input g2e_pkg::out_item_t out_data,
  input logic               out_strobe
);

  // An out-of-range point must come back with all coordinates cleared.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.coord_invalid |->
      out_data.ecef_x == '0 && out_data.ecef_y == '0 && out_data.ecef_z == '0)
    else $error("invalid point returned nonzero coordinates");

  // Reset flushes the whole pipeline.
  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

  // The datapath drains one request per cycle, so the queue never backs up.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised although the datapath never stalls");

  // Nothing comes out shortly after reset, before any request could get through.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_strobe ##1 !out_strobe ##1 !out_strobe)
    else $error("result appeared without a request");

endmodule

bind geodetic_to_ecef g2e_checker u_checker (.*);

// File: tb/geodetic_to_ecef_checker.sv
`timescale 1ns / 100ps

module geodetic_to_ecef_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  g2e_pkg::in_item_t  in_data,
  input  logic               out_strobe,
  input  g2e_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [32:0]        cfg_wdata,
  output int                 errors,
  output int                 pending
);

  localparam longint unsigned PI_W = 64'hC90FDAA22168C234;
  localparam longint GAIN = 652032874;
  localparam longint LAT_LIMIT = longint'(PI_W >> (63 - g2e_pkg::ANGLE_FRAC_BITS));
  localparam longint LON_LIMIT = longint'(PI_W >> (62 - g2e_pkg::ANGLE_FRAC_BITS));
  localparam longint PI_ANG = longint'((PI_W + 64'h8000_0000) >> 32);
  localparam longint HALF_PI_ANG = longint'((PI_W + 64'h1_0000_0000) >> 33);
  localparam longint SAT_HI = 64'sd34359738367;
  localparam longint SAT_LO = -64'sd34359738368;

  longint unsigned radius, ratio, ecc;
  longint arctan_tab [g2e_pkg::CORDIC_STAGES];
  g2e_pkg::out_item_t ecef_expected [$];

  assign pending = ecef_expected.size();

  initial begin
    longint unsigned acc, term;
    int unsigned sh;
    errors = 0;
    for (int i = 0; i < g2e_pkg::CORDIC_STAGES; i++) begin
      acc = 0;
      if (i == 0) begin
        acc = PI_W >> 2;
      end else begin
        for (int k = 0; k < 64; k++) begin
          sh = i * (2 * k + 1);
          if (sh > 62) break;
          term = ((64'd1 << 62) >> sh) / (2 * k + 1);
          if (k % 2) acc = acc - term; else acc = acc + term;
        end
      end
      arctan_tab[i] = longint'((acc + 64'h8000_0000) >> 32);
    end
  end

  // Rounded product a*c/2^sh, ties away from zero.
  function automatic longint round_mul(longint a, longint c, int sh);
    bit neg;
    longint unsigned ma, mc, hi, lo, res;
    neg = (a < 0) != (c < 0);
    ma = (a < 0) ? 64'd0 - longint'(a) : a;
    mc = (c < 0) ? 64'd0 - longint'(c) : c;
    hi = ma >> sh;
    lo = ma & ((64'd1 << sh) - 1);
    res = hi * mc + ((lo * mc + (64'd1 << (sh - 1))) >> sh);
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic void rotate(longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = GAIN; y = 0; z = ang;
    for (int i = 0; i < g2e_pkg::CORDIC_STAGES; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_tab[i];
      end else begin
        x += dx; y -= dy; z += arctan_tab[i];
      end
    end
    c = x; s = y;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < g2e_pkg::CORDIC_STAGES; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_tab[i];
      end else begin
        x -= dx; y += dy; z -= arctan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [35:0] to_mm(longint q16);
    longint v;
    v = (q16 + 32768) >>> 16;
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[35:0];
  endfunction

  function automatic g2e_pkg::out_item_t convert_point(g2e_pkg::in_item_t p);
    g2e_pkg::out_item_t o;
    longint lat, lon, h, latq, lonq, clat, slat, clon, slon, cg, sg, ky, g;
    longint s2, es2, r16, h16, rho;
    longint unsigned d, sq, num, q, rem;
    bit flip;
    lat = p.latitude; lon = p.longitude; h = p.altitude_mm;
    o = '0;
    if ((lat < 0 ? -lat : lat) > LAT_LIMIT || (lon < 0 ? -lon : lon) > LON_LIMIT) begin
      o.coord_invalid = 1'b1;
      return o;
    end
    latq = lat * (64'sd1 << (30 - g2e_pkg::ANGLE_FRAC_BITS));
    lonq = lon * (64'sd1 << (30 - g2e_pkg::ANGLE_FRAC_BITS));
    flip = 0;
    rotate(latq, clat, slat);
    if (lonq > HALF_PI_ANG) begin
      lonq -= PI_ANG; flip = 1;
    end else if (lonq < -HALF_PI_ANG) begin
      lonq += PI_ANG; flip = 1;
    end
    rotate(lonq, clon, slon);
    if (flip) begin
      clon = -clon; slon = -slon;
    end
    ky = round_mul(longint'(ratio), slat, 32);
    g = vector_angle(clat, ky);
    rotate(g, cg, sg);
    s2 = round_mul(sg, sg, 30);
    es2 = round_mul(longint'(ecc), s2, 32);
    d = (64'd1 << 30) + es2;
    sq = int_sqrt(d << 30);
    num = radius << 30;
    q = num / sq; rem = num % sq;
    r16 = longint'((q << 16) | ((rem << 16) / sq));
    h16 = h * 65536;
    rho = round_mul(r16, cg, 30) + round_mul(h16, clat, 30);
    o.ecef_x = to_mm(round_mul(rho, clon, 30));
    o.ecef_y = to_mm(round_mul(rho, slon, 30));
    o.ecef_z = to_mm(round_mul(r16, sg, 30) + round_mul(h16, slat, 30));
    return o;
  endfunction

  always @(posedge clk) begin
    g2e_pkg::out_item_t want;
    if (!rst_n) begin
      radius <= g2e_pkg::RADIUS_RST;
      ratio  <= g2e_pkg::RATIO_RST;
      ecc    <= g2e_pkg::ECC_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          g2e_pkg::CFG_RADIUS: radius <= cfg_wdata;
          g2e_pkg::CFG_RATIO:  ratio  <= cfg_wdata[31:0];
          g2e_pkg::CFG_ECC:    ecc    <= cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (start && !busy) ecef_expected.push_back(convert_point(in_data));
      if (out_strobe) begin
        if (ecef_expected.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = ecef_expected.pop_front();
          if (out_data.ecef_x !== want.ecef_x) begin
            $error("ecef_x expected %0d got %0d", want.ecef_x, out_data.ecef_x);
            errors++;
          end
          if (out_data.ecef_y !== want.ecef_y) begin
            $error("ecef_y expected %0d got %0d", want.ecef_y, out_data.ecef_y);
            errors++;
          end
          if (out_data.ecef_z !== want.ecef_z) begin
            $error("ecef_z expected %0d got %0d", want.ecef_z, out_data.ecef_z);
            errors++;
          end
          if (out_data.coord_invalid !== want.coord_invalid) begin
            $error("coord_invalid expected %0d got %0d", want.coord_invalid,
                   out_data.coord_invalid);
            errors++;
          end
        end
      end
    end
  end
endmodule

// File: tb/geodetic_to_ecef_test.sv
`timescale 1ns / 100ps

module geodetic_to_ecef_test;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int LAT_LIM = int'(g2e_pkg::PI_Q62 >> (63 - g2e_pkg::ANGLE_FRAC_BITS));
  localparam int LON_LIM = int'(g2e_pkg::PI_Q62 >> (62 - g2e_pkg::ANGLE_FRAC_BITS));
  localparam int HALF_PI_IN = int'(g2e_pkg::HPI_Q30_W >> 1);
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 400;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  g2e_pkg::in_item_t in_data = '0;
  logic out_strobe;
  g2e_pkg::out_item_t out_data;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [32:0] cfg_wdata = '0;
  int errors, pending;
  int cycles = 0;
  bit quiet;

  always #4 clk = ~clk;

  geodetic_to_ecef dut (.*);

  geodetic_to_ecef_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_point(int lat, int lon, int alt);
    if (!quiet) begin
      while ($urandom_range(99) < 7) begin
        start <= 0;
        @(posedge clk);
      end
    end
    start <= 1;
    in_data <= '{latitude: lat, longitude: lon, altitude_mm: alt};
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [32:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic int pick_angle(int lim);
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(1) ? lim : -lim;
    if (r < 15) return $urandom_range(1) ? lim + 1 : -lim - 1;
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) begin
      quiet = (i >= 60 && i < 160);
      if ($urandom_range(9) == 0)
        send_point($urandom, $urandom, $urandom);
      else
        send_point(pick_angle(LAT_LIM), pick_angle(LON_LIM),
                   $urandom_range(3) == 0 ? $urandom : int'($urandom_range(20000000)) - 500000);
    end
    quiet = 0;
  endtask

  initial begin
    quiet = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed points at the default ellipsoid.
    send_point(0, 0, 0);
    send_point(LAT_LIM, 0, 1000);
    send_point(-LAT_LIM, 12345, -1000);
    send_point(LAT_LIM + 1, 0, 0);
    send_point(-LAT_LIM - 1, 0, 0);
    send_point(0, LON_LIM, 0);
    send_point(0, -LON_LIM, 0);
    send_point(0, LON_LIM + 1, 0);
    send_point(0, -LON_LIM - 1, 0);
    send_point(0, HALF_PI_IN, 0);
    send_point(0, HALF_PI_IN + 1, 0);
    send_point(0, -HALF_PI_IN - 1, 0);
    send_point(32'h7FFF_FFFF, 0, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(100000000, 200000000, 32'h7FFF_FFFF);
    send_point(-300000000, -1500000000, 32'h8000_0000);
    send_point(LAT_LIM, LON_LIM, 32'h7FFF_FFFF);
    send_point(-LAT_LIM, -LON_LIM, 32'h8000_0000);
    send_point(1, -1, 1);
    random_points(150);

    // The sender holds off until every request has come back.
    drain();
    random_points(40);
    drain();

    write_reg(g2e_pkg::CFG_RADIUS, 33'h1_FFFF_FFFF);
    write_reg(g2e_pkg::CFG_RATIO, 32'hFFFF_FFFF);
    write_reg(g2e_pkg::CFG_ECC, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED, 33'h0_1234_5678);
    send_point(LAT_LIM, 0, 32'h7FFF_FFFF);
    send_point(0, LON_LIM, 32'h7FFF_FFFF);
    random_points(110);
    drain();

    write_reg(g2e_pkg::CFG_RADIUS, 33'd0);
    write_reg(g2e_pkg::CFG_RATIO, 32'd0);
    write_reg(g2e_pkg::CFG_ECC, 32'd0);
    send_point(LAT_LIM, LON_LIM, 32'h8000_0000);
    random_points(90);
    drain();

    write_reg(g2e_pkg::CFG_RADIUS, {1'($urandom_range(1)), 32'($urandom)});
    write_reg(g2e_pkg::CFG_RATIO, $urandom);
    write_reg(g2e_pkg::CFG_ECC, $urandom);
    random_points(90);
    drain();

    write_reg(g2e_pkg::CFG_RADIUS, g2e_pkg::RADIUS_RST);
    write_reg(g2e_pkg::CFG_RATIO, g2e_pkg::RATIO_RST);
    write_reg(g2e_pkg::CFG_ECC, g2e_pkg::ECC_RST);
    random_points(150);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
